// ===== hw/rtl/dqpc_pkg.sv =====
`timescale 1ns / 1ps

package dqpc_pkg;

    // width of the position fields on the result channel
    localparam int OUT_POS_WIDTH = 32;

    typedef logic [1:0] phase_t;

    typedef struct packed {
        phase_t enc_x_sample;
        phase_t enc_y_sample;
        logic   left_switch;
        logic   top_switch;
        logic   homing_mode;
        logic   clear_position;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_POS_WIDTH-1:0] position_x;
        logic signed [OUT_POS_WIDTH-1:0] position_y;
        logic                            left_on_event;
        logic                            left_off_event;
        logic                            top_on_event;
        logic                            top_off_event;
        logic                            x_illegal_step;
        logic                            y_illegal_step;
    } result_t;

    typedef struct packed {
        logic left_on;
        logic left_off;
        logic top_on;
        logic top_off;
    } switch_events_t;

    // next phase pair in the counting-up direction: 00 -> 01 -> 11 -> 10 -> 00
    function automatic phase_t gray_next_up(phase_t p);
        phase_t n;
        case (p)
            2'b00:   n = 2'b01;
            2'b01:   n = 2'b11;
            2'b11:   n = 2'b10;
            2'b10:   n = 2'b00;
            default: n = 2'b00;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/dqpc_stream_if.sv =====
`timescale 1ns / 1ps

interface dqpc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/dqpc_axis.sv =====
`timescale 1ns / 1ps

module dqpc_axis
    import dqpc_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             clear,
    input  phase_t           phases,
    output logic [WIDTH-1:0] count_next,
    output logic             illegal
);

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN,
        STEP_ILLEGAL
    } step_t;

    phase_t            prev_reg;
    logic [WIDTH-1:0]  count_reg;
    step_t             step;

    always_comb
    begin
        if (prev_reg == phases)
        begin
            step = STEP_NONE;
        end
        else if ((prev_reg ^ phases) == 2'b11)
        begin
            step = STEP_ILLEGAL;
        end
        else if (gray_next_up(prev_reg) == phases)
        begin
            step = STEP_UP;
        end
        else
        begin
            step = STEP_DOWN;
        end
    end

    assign illegal = (step == STEP_ILLEGAL);

    always_comb
    begin
        if (clear)
        begin
            count_next = '0;
        end
        else
        begin
            case (step)
                STEP_UP:   count_next = count_reg + WIDTH'(1);
                STEP_DOWN: count_next = count_reg - WIDTH'(1);
                default:   count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            prev_reg  <= phases;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/dqpc_switches.sv =====
`timescale 1ns / 1ps

module dqpc_switches
    import dqpc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  sample_t        sample,
    output switch_events_t events
);

    logic left_prev_reg;
    logic top_prev_reg;

    always_comb
    begin
        events.left_on  = sample.homing_mode &  sample.left_switch & ~left_prev_reg;
        events.left_off = sample.homing_mode & ~sample.left_switch &  left_prev_reg;
        events.top_on   = sample.homing_mode &  sample.top_switch  & ~top_prev_reg;
        events.top_off  = sample.homing_mode & ~sample.top_switch  &  top_prev_reg;
    end

    // previous levels track even outside homing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_prev_reg <= 1'b0;
            top_prev_reg  <= 1'b0;
        end
        else if (advance)
        begin
            left_prev_reg <= sample.left_switch;
            top_prev_reg  <= sample.top_switch;
        end
    end

endmodule

// ===== hw/rtl/dual_quadrature_position_counter.sv =====
`timescale 1ns / 1ps

// channel   | modport | payload  | beat
// ----------+---------+----------+-------------------------------------------
// samples   | sink    | sample_t | one sample of both encoders and switches
// results   | source  | result_t | positions, switch events, illegal flags
//
// one beat per clock sustained while results.ready stays high; a sample is
// registered in the input register, and its result in the result register
// decode and count run in the single stage between the two registers
// reset (rst_n low, asynchronous) zeroes both counters and previous samples
// a stalled result holds; the input register keeps filling behind it until
// both stages are full, then samples.ready drops

module dual_quadrature_position_counter
    import dqpc_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    dqpc_stream_if.sink   samples,
    dqpc_stream_if.source results
);

    // input register stage
    logic    in_valid_reg;
    sample_t in_sample_reg;

    // result register stage
    logic    out_valid_reg;
    result_t out_result_reg;

    logic    advance;      // input stage moves into the result stage
    logic    take_sample;

    logic [POSITION_WIDTH-1:0] count_x_next;
    logic [POSITION_WIDTH-1:0] count_y_next;
    logic                      x_illegal;
    logic                      y_illegal;
    switch_events_t            events;
    logic [OUT_POS_WIDTH-1:0]  pos_x_out;
    logic [OUT_POS_WIDTH-1:0]  pos_y_out;
    result_t                   result_next;

    // result stage frees up when empty or being read this cycle
    assign advance       = in_valid_reg & (~out_valid_reg | results.ready);
    assign samples.ready = ~in_valid_reg | advance;
    assign take_sample   = samples.valid & samples.ready;

    // per-axis decode and counter; state commits only when the item moves on
    dqpc_axis #(
        .WIDTH (POSITION_WIDTH)
    ) u_axis_x (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .clear      (in_sample_reg.clear_position),
        .phases     (in_sample_reg.enc_x_sample),
        .count_next (count_x_next),
        .illegal    (x_illegal)
    );

    dqpc_axis #(
        .WIDTH (POSITION_WIDTH)
    ) u_axis_y (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .clear      (in_sample_reg.clear_position),
        .phases     (in_sample_reg.enc_y_sample),
        .count_next (count_y_next),
        .illegal    (y_illegal)
    );

    // switch edge detection, gated by homing
    dqpc_switches u_switches (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (in_sample_reg),
        .events  (events)
    );

    // fit the counter onto the fixed-width position field
    generate
        if (POSITION_WIDTH >= OUT_POS_WIDTH)
        begin : g_pos_trunc
            assign pos_x_out = count_x_next[OUT_POS_WIDTH-1:0];
            assign pos_y_out = count_y_next[OUT_POS_WIDTH-1:0];
        end
        else
        begin : g_pos_sext
            assign pos_x_out = {{(OUT_POS_WIDTH-POSITION_WIDTH){count_x_next[POSITION_WIDTH-1]}},
                                count_x_next};
            assign pos_y_out = {{(OUT_POS_WIDTH-POSITION_WIDTH){count_y_next[POSITION_WIDTH-1]}},
                                count_y_next};
        end
    endgenerate

    always_comb
    begin
        result_next.position_x     = signed'(pos_x_out);
        result_next.position_y     = signed'(pos_y_out);
        result_next.left_on_event  = events.left_on;
        result_next.left_off_event = events.left_off;
        result_next.top_on_event   = events.top_on;
        result_next.top_off_event  = events.top_off;
        result_next.x_illegal_step = x_illegal;
        result_next.y_illegal_step = y_illegal;
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (samples.ready)
            begin
                in_valid_reg <= samples.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            in_sample_reg <= samples.payload;
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_result_reg;

endmodule
